>>> rtl/core/psgm_pkg.sv
// ----------------------------------------------------------------------------
// psgm_pkg
// Shared types and constants for the per-sender sequence gap monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package psgm_pkg;

  localparam int ADDR_W = 64;
  localparam int SEQ_W  = 32;
  localparam int TIME_W = 32;

  // entries in the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // one classified word as it travels from the front to the back
  typedef struct packed {
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic              ok;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] delay;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/per_sender_sequence_gap_monitor.sv
// ----------------------------------------------------------------------------
// per_sender_sequence_gap_monitor
// Tracks received-packet reports per sender: one-way delay and skipped
// sequence numbers.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  input   | in_valid / in_ready   | source_address_high/low, parse_valid,
//          |                       | sequence_number, send_time, receive_time
//  output  | out_valid / out_ready | one_way_delay, gap_count, sender_tracked,
//          |                       | new_sender
//
// The back unit takes a word only in its match state and then holds it in its
// update state, so it cannot take the next word until that update has finished.
// A word passes the front stage, the queue and the back unit's registers.
// Reset clears the slot table's in-use flags and all valid flags.
// A stalled output holds the back unit; the queue and front keep accepting
// until they fill.
// ----------------------------------------------------------------------------
`default_nettype none

module per_sender_sequence_gap_monitor #(
  parameter int SENDER_SLOTS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [psgm_pkg::ADDR_W-1:0] source_address_high,
  input  wire logic [psgm_pkg::ADDR_W-1:0] source_address_low,
  input  wire logic                        parse_valid,
  input  wire logic [psgm_pkg::SEQ_W-1:0]  sequence_number,
  input  wire logic [psgm_pkg::TIME_W-1:0] send_time,
  input  wire logic [psgm_pkg::TIME_W-1:0] receive_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [psgm_pkg::TIME_W-1:0]      one_way_delay,
  output logic [psgm_pkg::SEQ_W-1:0]       gap_count,
  output logic                             sender_tracked,
  output logic                             new_sender
);
  import psgm_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  psgm_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .source_address_high (source_address_high),
    .source_address_low  (source_address_low),
    .parse_valid         (parse_valid),
    .sequence_number     (sequence_number),
    .send_time           (send_time),
    .receive_time        (receive_time),
    .push_valid          (push_valid),
    .push_ready          (push_ready),
    .push_item           (push_item)
  );

  psgm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  psgm_back #(
    .SENDER_SLOTS (SENDER_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .one_way_delay  (one_way_delay),
    .gap_count      (gap_count),
    .sender_tracked (sender_tracked),
    .new_sender     (new_sender)
  );

endmodule

`default_nettype wire

>>> rtl/core/psgm_front.sv
// ----------------------------------------------------------------------------
// psgm_front
// Input stage: accept a report, compute its delay and stage it for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module psgm_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [psgm_pkg::ADDR_W-1:0] source_address_high,
  input  wire logic [psgm_pkg::ADDR_W-1:0] source_address_low,
  input  wire logic                       parse_valid,
  input  wire logic [psgm_pkg::SEQ_W-1:0]  sequence_number,
  input  wire logic [psgm_pkg::TIME_W-1:0] send_time,
  input  wire logic [psgm_pkg::TIME_W-1:0] receive_time,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output psgm_pkg::item_t                 push_item
);
  import psgm_pkg::*;

  logic  stage_valid;
  item_t stage_item;
  logic  accept;

  assign in_ready   = !stage_valid || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = stage_valid;
  assign push_item  = stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.addr_high <= source_address_high;
      stage_item.addr_low  <= source_address_low;
      stage_item.ok        <= parse_valid;
      stage_item.seq       <= sequence_number;
      // zero the delay of a report whose payload did not parse
      stage_item.delay     <= parse_valid ? (receive_time - send_time) : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/psgm_queue.sv
// ----------------------------------------------------------------------------
// psgm_queue
// Short FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module psgm_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  psgm_pkg::item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output psgm_pkg::item_t pop_item
);
  import psgm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/psgm_back.sv
// ----------------------------------------------------------------------------
// psgm_back
// Sender table: associative match or claim, then sequence update and result.
// ----------------------------------------------------------------------------
`default_nettype none

module psgm_back #(
  parameter int SENDER_SLOTS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pop_valid,
  output logic                            pop_ready,
  input  psgm_pkg::item_t                 pop_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [psgm_pkg::TIME_W-1:0]      one_way_delay,
  output logic [psgm_pkg::SEQ_W-1:0]       gap_count,
  output logic                            sender_tracked,
  output logic                            new_sender
);
  import psgm_pkg::*;

  localparam int IDX_W = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;

  typedef enum logic {
    ST_MATCH,
    ST_UPDATE
  } state_t;

  state_t state;

  // address CAM, each entry compared in place
  logic [ADDR_W-1:0]     cam_high [SENDER_SLOTS];
  logic [ADDR_W-1:0]     cam_low  [SENDER_SLOTS];
  logic [SENDER_SLOTS-1:0] in_use;
  logic [SENDER_SLOTS-1:0] match;

  // last sequence number per slot
  logic [SEQ_W-1:0] seq_mem [SENDER_SLOTS];
  logic [SEQ_W-1:0] rd_last;

  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] look_idx;
  logic             hit;
  logic             full;
  logic             claim;
  logic             take;

  // item under update
  logic [IDX_W-1:0]  cur_idx;
  logic              cur_hit;
  logic              cur_fresh;
  logic              cur_ok;
  logic [SEQ_W-1:0]  cur_seq;
  logic [TIME_W-1:0] cur_delay;

  logic              finish;
  logic              tracked;
  logic [SEQ_W-1:0]  last;
  logic [SEQ_W-1:0]  next_seq;
  logic [SEQ_W-1:0]  gap;
  logic              mem_we;

  for (genvar g = 0; g < SENDER_SLOTS; g++) begin : g_cmp
    assign match[g] = in_use[g] && (cam_high[g] == pop_item.addr_high) &&
                      (cam_low[g] == pop_item.addr_low);
  end

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = SENDER_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = IDX_W'(i);
      end
      if (!in_use[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign full      = &in_use;
  assign look_idx  = hit ? match_idx : free_idx;
  assign pop_ready = (state == ST_MATCH);
  assign take      = pop_valid && pop_ready;
  assign claim     = take && !hit && !full;

  assign finish   = (state == ST_UPDATE) && (!out_valid || out_ready);
  assign tracked  = cur_hit || cur_fresh;
  assign last     = cur_fresh ? '0 : rd_last;
  assign next_seq = last + 1'b1;
  assign gap      = (cur_ok && tracked && (cur_seq > next_seq)) ? (cur_seq - next_seq) : '0;
  // a claim always writes, so a slot in use never reads stale data
  assign mem_we   = finish && tracked && (cur_ok || cur_fresh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_MATCH;
      in_use    <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_MATCH: begin
          if (take) begin
            state <= ST_UPDATE;
          end
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_UPDATE: begin
          if (finish) begin
            state     <= ST_MATCH;
            out_valid <= 1'b1;
          end
        end
        default: state <= ST_MATCH;
      endcase
      if (claim) begin
        in_use[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      cam_high[free_idx] <= pop_item.addr_high;
      cam_low[free_idx]  <= pop_item.addr_low;
    end
    if (take) begin
      cur_idx   <= look_idx;
      cur_hit   <= hit;
      cur_fresh <= !hit && !full;
      cur_ok    <= pop_item.ok;
      cur_seq   <= pop_item.seq;
      cur_delay <= pop_item.delay;
    end
    if (finish) begin
      one_way_delay  <= cur_delay;
      gap_count      <= gap;
      sender_tracked <= tracked;
      new_sender     <= cur_fresh;
    end
  end

  // hold the read word through a stalled update
  always_ff @(posedge clk) begin
    if (take) begin
      rd_last <= seq_mem[look_idx];
    end
    if (mem_we) begin
      seq_mem[cur_idx] <= cur_ok ? cur_seq : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/psgm_checker.sv
// ----------------------------------------------------------------------------
// psgm_checker
// Port-level checks for the per-sender sequence gap monitor.
// ----------------------------------------------------------------------------
`default_nettype none

module psgm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] one_way_delay,
  input wire logic [31:0] gap_count,
  input wire logic        sender_tracked,
  input wire logic        new_sender
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(one_way_delay) &&
    $stable(gap_count) && $stable(sender_tracked) && $stable(new_sender))
    else $error("output word changed while stalled");

  a_fresh_tracked: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_sender |-> sender_tracked)
    else $error("new sender reported without a slot");

  a_full_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sender_tracked |-> gap_count == '0)
    else $error("gap reported for untracked sender");

  // results take at least a match and an update after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind per_sender_sequence_gap_monitor psgm_checker u_psgm_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .one_way_delay  (one_way_delay),
  .gap_count      (gap_count),
  .sender_tracked (sender_tracked),
  .new_sender     (new_sender)
);

`default_nettype wire
